// ===== rtl/core/adaptive_state_feedback_controller_unit_assert.svh =====
// Assertion macros for the adaptive state feedback controller
`ifndef ADAPTIVE_STATE_FEEDBACK_CONTROLLER_UNIT_ASSERT_SVH
`define ADAPTIVE_STATE_FEEDBACK_CONTROLLER_UNIT_ASSERT_SVH
`ifndef SYNTHESIS
`define ASFC_ASSERT_NOW(label, clk, rst, pre, post) \
   label: assert property (@(posedge clk) disable iff (rst) (pre) |-> (post)) \
      else $error("assertion failed");
`define ASFC_ASSERT_NEXT(label, clk, rst, pre, post) \
   label: assert property (@(posedge clk) disable iff (rst) (pre) |=> (post)) \
      else $error("assertion failed");
`else
`define ASFC_ASSERT_NOW(label, clk, rst, pre, post)
`define ASFC_ASSERT_NEXT(label, clk, rst, pre, post)
`endif
`endif

// ===== rtl/core/asfc_pkg.sv =====
// Shared types and constants of the adaptive state feedback controller
package asfc_pkg;

   localparam int FRAC_BITS = 16;
   localparam int NUM_GAINS = 4;
   localparam int WORD_W    = 32;
   localparam int X_W       = WORD_W + 1;
   localparam int PROD_W    = WORD_W + X_W - FRAC_BITS;
   localparam int SUM_W     = PROD_W + 2;
   localparam int LR_W      = 21;
   localparam int MOM_W     = 17;
   localparam int LIM_W     = 24;
   localparam int DRIVE_W   = 25;
   localparam int DIV_STEPS = WORD_W - 1;
   localparam int CNT_W     = $clog2(DIV_STEPS + 1);

   localparam logic [1:0] CSR_LEARN_RATE  = 2'd0;
   localparam logic [1:0] CSR_MOMENTUM    = 2'd1;
   localparam logic [1:0] CSR_DRIVE_LIMIT = 2'd2;

   localparam logic signed [WORD_W-1:0] RESET_GAIN [NUM_GAINS] = '{
      WORD_W'(15 * (2 ** FRAC_BITS)),
      WORD_W'(12 * (2 ** FRAC_BITS)),
      WORD_W'(-25 * (2 ** FRAC_BITS)),
      WORD_W'(-3 * (2 ** FRAC_BITS))
   };
   localparam logic [LIM_W-1:0] RESET_LIMIT = LIM_W'(10 * (2 ** FRAC_BITS));

   typedef enum logic [2:0] {
      ST_IDLE, ST_MUL, ST_DINIT, ST_DIV, ST_UPD, ST_SUM, ST_DONE
   } state_type;

   typedef struct packed {
      logic load;
      logic mul;
      logic dinit;
      logic dstep;
      logic upd;
      logic sum;
   } lane_ctrl_type;

   typedef struct packed {
      logic              adapt_enable;
      logic signed [31:0] plant_state_0;
      logic signed [31:0] plant_state_1;
      logic signed [31:0] plant_state_2;
      logic signed [31:0] plant_state_3;
   } req_type;

   typedef struct packed {
      logic signed [24:0] drive;
      logic signed [31:0] gain_out_0;
      logic signed [31:0] gain_out_1;
      logic signed [31:0] gain_out_2;
      logic signed [31:0] gain_out_3;
      logic               zero_gain_fault;
   } rsp_type;

endpackage

// ===== rtl/core/asfc_lane.sv =====
// One gain lane: product, squared state over gain, and gain update
module asfc_lane (
   input  logic                                    clock,
   input  logic                                    reset,
   input  asfc_pkg::lane_ctrl_type                 ctrl,
   input  logic signed [asfc_pkg::X_W-1:0]         x_in,
   input  logic signed [asfc_pkg::WORD_W-1:0]      rst_gain,
   input  logic [asfc_pkg::LR_W-1:0]               learn_rate,
   input  logic [asfc_pkg::MOM_W-1:0]              momentum,
   output logic signed [asfc_pkg::WORD_W-1:0]      gain,
   output logic signed [asfc_pkg::PROD_W-1:0]      prod,
   output logic                                    zero
);
   localparam int W   = asfc_pkg::WORD_W;
   localparam int XW  = asfc_pkg::X_W;
   localparam int F   = asfc_pkg::FRAC_BITS;
   localparam int DWW = asfc_pkg::LR_W + 1 + XW - F;
   localparam int MMW = asfc_pkg::MOM_W + 1 + XW - F;
   localparam int NW  = W + 9;
   // signed 32-bit limits, held at the width of the update sum
   localparam logic signed [NW-1:0] NSAT_HI = {{(NW-W+1){1'b0}}, {(W-1){1'b1}}};
   localparam logic signed [NW-1:0] NSAT_LO = {{(NW-W+1){1'b1}}, {(W-1){1'b0}}};

   logic signed [W-1:0]                 gain_ff, prior_ff;
   logic signed [XW-1:0]                x_ff;
   logic signed [asfc_pkg::PROD_W-1:0]  prod_ff;
   logic [2*W-1:0]                      sq_ff;
   logic [W-1:0]                        rem_ff;
   logic [W-2:0]                        dvd_ff, quo_ff;
   logic                                sat_ff;
   logic signed [DWW-1:0]               dw_ff;
   logic signed [MMW-1:0]               mom_ff;

   logic [W-1:0]              xm, gm;
   logic signed [2*XW-1:0]    full_prod;
   logic [W:0]                hi, trial;
   logic [W-2:0]              q;
   logic signed [XW-1:0]      a, diff;
   logic signed [asfc_pkg::LR_W+1+XW-1:0]  dw_full;
   logic signed [asfc_pkg::MOM_W+1+XW-1:0] mom_full;
   logic signed [NW-1:0]      nsum;
   logic signed [W-1:0]       nsat;

   always_comb begin
      xm = x_ff[XW-1] ? W'(-x_ff) : W'(x_ff);
      gm = gain_ff[W-1] ? W'(-XW'(gain_ff)) : W'(gain_ff);
      full_prod = XW'(gain_ff) * x_ff;
      hi = sq_ff[2*W-1:W-1];
      trial = {rem_ff, dvd_ff[W-2]};
      q = sat_ff ? {(W-1){1'b1}} : quo_ff;
      if (gain_ff == '0) begin
         a = '0;
      end else if (gain_ff[W-1]) begin
         a = -$signed({2'b00, q});
      end else begin
         a = $signed({2'b00, q});
      end
      diff = XW'(gain_ff) - XW'(prior_ff);
      dw_full = $signed({1'b0, learn_rate}) * a;
      mom_full = $signed({1'b0, momentum}) * diff;
      nsum = NW'(gain_ff) + NW'(dw_ff) + NW'(mom_ff);
      if (nsum > NSAT_HI) begin
         nsat = {1'b0, {(W-1){1'b1}}};
      end else if (nsum < NSAT_LO) begin
         nsat = {1'b1, {(W-1){1'b0}}};
      end else begin
         nsat = W'(nsum);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         gain_ff  <= rst_gain;
         prior_ff <= rst_gain;
      end else if (ctrl.sum) begin
         gain_ff  <= nsat;
         prior_ff <= gain_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (ctrl.load) begin
         x_ff <= x_in;
      end
      if (ctrl.mul) begin
         prod_ff <= asfc_pkg::PROD_W'(full_prod >>> F);
         sq_ff   <= xm * xm;
      end
      if (ctrl.dinit) begin
         sat_ff <= hi >= {1'b0, gm};
         rem_ff <= hi[W-1:0];
         dvd_ff <= sq_ff[W-2:0];
         quo_ff <= '0;
      end else if (ctrl.dstep) begin
         if (trial >= {1'b0, gm}) begin
            rem_ff <= W'(trial - {1'b0, gm});
            quo_ff <= {quo_ff[W-3:0], 1'b1};
         end else begin
            rem_ff <= trial[W-1:0];
            quo_ff <= {quo_ff[W-3:0], 1'b0};
         end
         dvd_ff <= {dvd_ff[W-3:0], 1'b0};
      end
      if (ctrl.upd) begin
         dw_ff  <= DWW'(dw_full >>> F);
         mom_ff <= MMW'(mom_full >>> F);
      end
   end

   assign gain = gain_ff;
   assign prod = prod_ff;
   assign zero = (gain_ff == '0);

endmodule

// ===== rtl/core/asfc_merge.sv =====
// Sums the lane products into the drive and clamps it
module asfc_merge (
   input  logic signed [asfc_pkg::PROD_W-1:0] prod [asfc_pkg::NUM_GAINS],
   input  logic [asfc_pkg::LIM_W-1:0]         drive_limit,
   output logic signed [asfc_pkg::DRIVE_W-1:0] drive
);
   localparam int SW = asfc_pkg::SUM_W;

   logic signed [SW-1:0] s01, s23, total, lim;

   always_comb begin
      s01   = SW'(prod[0]) + SW'(prod[1]);
      s23   = SW'(prod[2]) + SW'(prod[3]);
      total = s01 + s23;
      lim   = SW'(drive_limit);
      if (total > lim) begin
         drive = asfc_pkg::DRIVE_W'(lim);
      end else if (total < -lim) begin
         drive = asfc_pkg::DRIVE_W'(-lim);
      end else begin
         drive = asfc_pkg::DRIVE_W'(total);
      end
   end

endmodule

// ===== rtl/core/adaptive_state_feedback_controller_unit.sv =====
// Top level of the adaptive state feedback controller
//
//   channel  dir  ports                            word
//   req      in   req_valid req_stall req_data     enable + four plant states
//   rsp      out  rsp_valid rsp_stall rsp_data     drive, four gains, fault
//   csr      in   csr_we csr_index csr_wdata       learn_rate/momentum/limit
//
// An enabled word steps through a multiply state, a divide setup state, a
// 31-step restoring divide per lane (four lanes in parallel), an update
// state, a gain sum state and an output load that raises rsp_valid; a
// disabled word goes straight to the output load. Reset is synchronous and
// restores gains, configuration and sequencer. A new word is taken while the
// last result waits; a finished word holds in DONE while rsp_stall is high.
module adaptive_state_feedback_controller_unit (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             req_valid,
   output logic                             req_stall,
   input  asfc_pkg::req_type                req_data,
   output logic                             rsp_valid,
   input  logic                             rsp_stall,
   output asfc_pkg::rsp_type                rsp_data,
   input  logic                             csr_we,
   input  logic [1:0]                       csr_index,
   input  logic [asfc_pkg::LIM_W-1:0]       csr_wdata
);
   localparam int N  = asfc_pkg::NUM_GAINS;
   localparam int XW = asfc_pkg::X_W;

   asfc_pkg::state_type  state_ff, state_in;
   logic [asfc_pkg::CNT_W-1:0] cnt_ff, cnt_in;
   logic                 en_ff;
   logic                 rsp_valid_ff, rsp_valid_in;
   asfc_pkg::rsp_type    rsp_ff;
   logic [asfc_pkg::LR_W-1:0]  lr_ff;
   logic [asfc_pkg::MOM_W-1:0] mom_ff;
   logic [asfc_pkg::LIM_W-1:0] lim_ff;

   asfc_pkg::lane_ctrl_type ctrl;
   logic                    accept, out_free, load_rsp;
   logic signed [XW-1:0]    x_in [N];
   logic signed [asfc_pkg::WORD_W-1:0] gain [N];
   logic signed [asfc_pkg::PROD_W-1:0] prod [N];
   logic [N-1:0]            zero;
   logic signed [asfc_pkg::DRIVE_W-1:0] drive;

   assign accept   = req_valid && !req_stall;
   assign out_free = !rsp_valid_ff || !rsp_stall;

   // first two states are negated at 33 bits so the most negative value holds
   assign x_in[0] = -XW'(req_data.plant_state_0);
   assign x_in[1] = -XW'(req_data.plant_state_1);
   assign x_in[2] = XW'(req_data.plant_state_2);
   assign x_in[3] = XW'(req_data.plant_state_3);

   // configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         lr_ff  <= '0;
         mom_ff <= '0;
         lim_ff <= asfc_pkg::RESET_LIMIT;
      end else if (csr_we) begin
         unique case (csr_index)
            asfc_pkg::CSR_LEARN_RATE:  lr_ff  <= csr_wdata[asfc_pkg::LR_W-1:0];
            asfc_pkg::CSR_MOMENTUM:    mom_ff <= csr_wdata[asfc_pkg::MOM_W-1:0];
            asfc_pkg::CSR_DRIVE_LIMIT: lim_ff <= csr_wdata;
            default: ;
         endcase
      end
   end

   // sequencer
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= asfc_pkg::ST_IDLE;
         cnt_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         cnt_ff       <= cnt_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_comb begin
      state_in     = state_ff;
      cnt_in       = cnt_ff;
      ctrl         = '0;
      req_stall    = 1'b1;
      load_rsp     = 1'b0;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      unique case (state_ff)
         asfc_pkg::ST_IDLE: begin
            req_stall = 1'b0;
            ctrl.load = accept;
            if (accept) begin
               state_in = req_data.adapt_enable ? asfc_pkg::ST_MUL : asfc_pkg::ST_DONE;
            end
         end
         asfc_pkg::ST_MUL: begin
            ctrl.mul = 1'b1;
            state_in = asfc_pkg::ST_DINIT;
         end
         asfc_pkg::ST_DINIT: begin
            ctrl.dinit = 1'b1;
            cnt_in     = asfc_pkg::CNT_W'(asfc_pkg::DIV_STEPS);
            state_in   = asfc_pkg::ST_DIV;
         end
         asfc_pkg::ST_DIV: begin
            ctrl.dstep = 1'b1;
            cnt_in     = cnt_ff - 1'b1;
            if (cnt_ff == asfc_pkg::CNT_W'(1)) begin
               state_in = asfc_pkg::ST_UPD;
            end
         end
         asfc_pkg::ST_UPD: begin
            ctrl.upd = 1'b1;
            state_in = asfc_pkg::ST_SUM;
         end
         asfc_pkg::ST_SUM: begin
            ctrl.sum = 1'b1;
            state_in = asfc_pkg::ST_DONE;
         end
         asfc_pkg::ST_DONE: begin
            if (out_free) begin
               load_rsp     = 1'b1;
               rsp_valid_in = 1'b1;
               state_in     = asfc_pkg::ST_IDLE;
            end
         end
         default: state_in = asfc_pkg::ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         en_ff <= req_data.adapt_enable;
      end
   end

   for (genvar i = 0; i < N; i++) begin : g_lane
      asfc_lane u_lane (
         .clock      (clock),
         .reset      (reset),
         .ctrl       (ctrl),
         .x_in       (x_in[i]),
         .rst_gain   (asfc_pkg::RESET_GAIN[i]),
         .learn_rate (lr_ff),
         .momentum   (mom_ff),
         .gain       (gain[i]),
         .prod       (prod[i]),
         .zero       (zero[i])
      );
   end

   // products still hold the pre-update gains, so the drive uses old gains
   asfc_merge u_merge (
      .prod        (prod),
      .drive_limit (lim_ff),
      .drive       (drive)
   );

   // fault looks at the gains before update: sample it at SUM time
   logic fault_ff;
   always_ff @(posedge clock) begin
      if (ctrl.sum) begin
         fault_ff <= |zero;
      end
   end

   always_ff @(posedge clock) begin
      if (load_rsp) begin
         rsp_ff.drive           <= en_ff ? drive : '0;
         rsp_ff.gain_out_0      <= gain[0];
         rsp_ff.gain_out_1      <= gain[1];
         rsp_ff.gain_out_2      <= gain[2];
         rsp_ff.gain_out_3      <= gain[3];
         rsp_ff.zero_gain_fault <= en_ff && fault_ff;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   `include "adaptive_state_feedback_controller_unit_assert.svh"

   `ASFC_ASSERT_NEXT(a_accept_busy, clock, reset, accept, req_stall)
   `ASFC_ASSERT_NOW(a_cnt_div, clock, reset, state_ff == asfc_pkg::ST_DIV, cnt_ff != '0)
   `ASFC_ASSERT_NEXT(a_done_out, clock, reset, load_rsp, rsp_valid && state_ff == asfc_pkg::ST_IDLE)

endmodule
